@@ hw/rtl/stl_pkg.sv @@
// Package for the stripe target lookup block: field widths, register codes,
// and the types shared by the pipeline stages, the table and the channel interfaces.
// Depends on nothing.
package stl_pkg;

	localparam int MAX_GROUPS_DEF = 64;

	localparam int POS_W      = 63;
	localparam int SLOT_W     = 6;
	localparam int ID_W       = 16;
	localparam int SHIFT_W    = 5;
	localparam int GROUPS_W   = 7;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	// The chunk number runs through the remainder pipeline REM_BITS bits per stage.
	localparam int QUO_W      = POS_W + 1;
	localparam int REM_BITS   = 8;
	localparam int REM_STAGES = QUO_W / REM_BITS;

	localparam logic [SHIFT_W-1:0]  SHIFT_RST  = SHIFT_W'(19);
	localparam logic [GROUPS_W-1:0] GROUPS_RST = GROUPS_W'(1);

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHUNK_SHIFT = 4'd0,
		CFG_NUM_GROUPS  = 4'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [SHIFT_W-1:0]  shift;
		logic [GROUPS_W-1:0] groups;
	} stl_cfg_t;

	typedef struct packed {
		logic                lookup;
		logic [SLOT_W-1:0]   slot;
		logic [ID_W-1:0]     id;
		logic [QUO_W-1:0]    quo;
		logic [GROUPS_W-1:0] rem;
	} stl_item_t;

endpackage

@@ hw/rtl/stl_if.sv @@
// Channel interfaces of the stripe target lookup block: request, result and
// configuration write. Each carries valid, ready and its payload.
// Depends on stl_pkg.
interface stl_req_if import stl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [POS_W-1:0]  pos;
	logic [SLOT_W-1:0] entry_index;
	logic [ID_W-1:0]   entry_id;

	modport source(output valid, req_type, pos, entry_index, entry_id, input ready);
	modport sink(input valid, req_type, pos, entry_index, entry_id, output ready);
endinterface

interface stl_rsp_if import stl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] target_index;
	logic [ID_W-1:0]   group_id;

	modport source(output valid, target_index, group_id, input ready);
	modport sink(input valid, target_index, group_id, output ready);
endinterface

interface stl_cfg_if import stl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hw/rtl/stl_front.sv @@
// First pipeline stage: registers an accepted transaction and turns the byte
// offset into a chunk number by shifting out the chunk size.
// Depends on stl_pkg.
module stl_front import stl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  stl_cfg_t  cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  stl_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output stl_item_t out_item
);

	logic      valid_q;
	stl_item_t item_q;
	stl_item_t item_d;

	always_comb begin
		item_d     = in_item;
		item_d.quo = in_item.quo >> cfg.shift;
		item_d.rem = '0;
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item_d;
		end
	end

endmodule

@@ hw/rtl/stl_rem_stage.sv @@
// One stage of the remainder pipeline: folds the next REM_BITS chunk-number bits
// into the running remainder modulo the group count, restoring style.
// Depends on stl_pkg.
module stl_rem_stage import stl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  stl_cfg_t  cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  stl_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output stl_item_t out_item
);

	logic      valid_q;
	stl_item_t item_q;
	stl_item_t item_d;

	// The remainder stays below the group count, so each step needs at most
	// one subtraction.
	always_comb begin : step
		logic [GROUPS_W:0]   t;
		logic [GROUPS_W-1:0] r;
		r = in_item.rem;
		t = '0;
		for (int k = 0; k < REM_BITS; k++) begin
			t = {r, in_item.quo[QUO_W-1-k]};
			if (t >= {1'b0, cfg.groups}) begin
				t = t - {1'b0, cfg.groups};
			end
			r = t[GROUPS_W-1:0];
		end
		item_d     = in_item;
		item_d.quo = in_item.quo << REM_BITS;
		item_d.rem = r;
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item_d;
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(item_q))
		else $error("remainder stage lost or changed a stalled item");

endmodule

@@ hw/rtl/stl_table.sv @@
// Group table and result register: loads write the table, lookups read it,
// and the registered read data forms the result held for the consumer.
// Depends on stl_pkg.
module stl_table import stl_pkg::*; #(
	parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  stl_item_t         in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SLOT_W-1:0] target_index,
	output logic [ID_W-1:0]   group_id
);

	localparam int          AW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam logic [31:0] LAST = 32'(MAX_GROUPS - 1);

	logic [ID_W-1:0]   mem [0:MAX_GROUPS-1];
	logic [ID_W-1:0]   data_q;
	logic [SLOT_W-1:0] target_q;
	logic              out_valid_q;

	logic              adv_out;
	logic              wr_en;
	logic              rd_en;
	logic [31:0]       rem_w;
	logic [31:0]       idx_w;
	logic [AW-1:0]     addr;

	assign adv_out = !out_valid_q || out_ready;
	// Loads never wait for the result register.
	assign in_ready = !in_item.lookup || adv_out;

	assign rem_w = 32'(in_item.rem);
	assign idx_w = (rem_w > LAST) ? LAST : rem_w;

	assign wr_en = in_valid && !in_item.lookup && (32'(in_item.slot) <= LAST);
	assign rd_en = in_valid && in_item.lookup && adv_out;
	assign addr  = in_item.lookup ? AW'(idx_w) : AW'(in_item.slot);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= in_item.id;
		end
		if (rd_en) begin
			data_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			target_q <= idx_w[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= rd_en;
		end
	end

	assign out_valid    = out_valid_q;
	assign target_index = target_q;
	assign group_id     = data_q;

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(rd_en))
		else $error("result appeared without a table read");

	a_no_read_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !rd_en)
		else $error("table read overwrote a result still waiting");

endmodule

@@ hw/rtl/stripe_target_lookup.sv @@
// Stripe target lookup: one load or lookup per cycle is accepted unless a held result stalls.
// A lookup passes through one shift stage,
// eight remainder stages of eight bits each, then the table read into the result register.
// Loads produce no result and write the table when they reach the table stage.
// Reset clears the pipeline and sets chunk_shift to 19 and num_groups to 1; the table
// itself is not cleared and holds no valid data until loaded.
// Depends on stl_pkg, stl_if, stl_front, stl_rem_stage and stl_table.
module stripe_target_lookup import stl_pkg::*; #(
	parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	stl_req_if.sink     req,
	stl_rsp_if.source   rsp,
	stl_cfg_if.sink     cfg
);

	// The group count is clamped once, at the configuration write, to the
	// range from one to the table depth or 127, whichever is smaller. A count of zero acts as one.
	localparam int                  GCAP   = (MAX_GROUPS > 127) ? 127 : MAX_GROUPS;
	localparam logic [GROUPS_W-1:0] GCAP_V = GROUPS_W'(GCAP);

	logic [SHIFT_W-1:0]  shift_q;
	logic [GROUPS_W-1:0] groups_q;
	logic [GROUPS_W-1:0] cfg_groups;
	logic [GROUPS_W-1:0] groups_eff;
	stl_cfg_t            cfg_now;

	assign cfg.ready  = 1'b1;
	assign cfg_groups = cfg.data[GROUPS_W-1:0];
	assign groups_eff = (cfg_groups == '0) ? GROUPS_W'(1) :
	                    (cfg_groups > GCAP_V) ? GCAP_V : cfg_groups;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= SHIFT_RST;
			groups_q <= GROUPS_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_CHUNK_SHIFT: shift_q  <= cfg.data[SHIFT_W-1:0];
				CFG_NUM_GROUPS:  groups_q <= groups_eff;
				default: ;
			endcase
		end
	end

	assign cfg_now.shift  = shift_q;
	assign cfg_now.groups = groups_q;

	// The position is (offset >> shift) mod groups: the low chunk bits never
	// affect which chunk an offset falls in, so the shift comes first and the
	// remainder pipeline works on the chunk number.
	stl_item_t req_item;

	always_comb begin
		req_item.lookup = (req.req_type == REQ_LOOKUP);
		req_item.slot   = req.entry_index;
		req_item.id     = req.entry_id;
		req_item.quo    = {1'b0, req.pos};
		req_item.rem    = '0;
	end

	// Handshake chain between stages; entry 0 is the front stage's output,
	// entry k the output of remainder stage k.
	logic      chain_valid [0:REM_STAGES];
	logic      chain_ready [0:REM_STAGES];
	stl_item_t chain_item  [0:REM_STAGES];

	stl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_now),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_item   (req_item),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_item  (chain_item[0])
	);

	for (genvar g = 0; g < REM_STAGES; g++) begin : g_rem
		stl_rem_stage u_rem (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg_now),
			.in_valid  (chain_valid[g]),
			.in_ready  (chain_ready[g]),
			.in_item   (chain_item[g]),
			.out_valid (chain_valid[g+1]),
			.out_ready (chain_ready[g+1]),
			.out_item  (chain_item[g+1])
		);
	end

	// Loads and lookups reach the table in acceptance order and touch it at
	// the same stage, so a lookup always sees every earlier load.
	stl_table #(
		.MAX_GROUPS (MAX_GROUPS)
	) u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (chain_valid[REM_STAGES]),
		.in_ready     (chain_ready[REM_STAGES]),
		.in_item      (chain_item[REM_STAGES]),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.target_index (rsp.target_index),
		.group_id     (rsp.group_id)
	);

	a_stall_needs_blocked_result: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid && !rsp.ready)
		else $error("request side stalled while the result side was free");

	a_groups_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		groups_q != '0 && groups_q <= GCAP_V)
		else $error("group count register out of range");

endmodule
